// ----- src/cfp_pkg.sv -----
// Package for the framed packet parser: word types, register indexes, status codes,
// parse phases and CRC-32 constants. No dependencies.
`default_nettype none

package cfp_pkg;

  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'h5A;
  localparam int unsigned WRITE_DATA_MAX    = 256;
  localparam logic [8:0]  MAX_LEN_RESET     = 9'(4 + WRITE_DATA_MAX);
  localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [1:0] ST_IN_PROGRESS = 2'd0;
  localparam logic [1:0] ST_FRAME_READY = 2'd1;
  localparam logic [1:0] ST_CRC_ERROR   = 2'd2;
  localparam logic [1:0] ST_PARSE_ERROR = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [8:0]  payload_position;
    logic [7:0]  frame_command;
    logic [7:0]  frame_sequence;
    logic [8:0]  frame_length;
    logic [31:0] frame_crc;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [10:0] {
    PH_SYNC0   = 11'b000_0000_0001,
    PH_SYNC1   = 11'b000_0000_0010,
    PH_CMD     = 11'b000_0000_0100,
    PH_SEQ     = 11'b000_0000_1000,
    PH_LENLO   = 11'b000_0001_0000,
    PH_LENHI   = 11'b000_0010_0000,
    PH_PAYLOAD = 11'b000_0100_0000,
    PH_CRC0    = 11'b000_1000_0000,
    PH_CRC1    = 11'b001_0000_0000,
    PH_CRC2    = 11'b010_0000_0000,
    PH_CRC3    = 11'b100_0000_0000
  } phase_t;

endpackage

`default_nettype wire

// ----- src/cfp_crc.sv -----
// Byte-wide update of the reflected CRC-32 (eight bit steps unrolled).
// Depends on cfp_pkg for the polynomial.
`default_nettype none

module cfp_crc
  import cfp_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- src/cfp_parser.sv -----
// Parser core: configuration registers, phase machine, header and CRC state, and the
// result of one word. Depends on cfp_pkg and cfp_crc.
`default_nettype none

module cfp_parser
  import cfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_wr_t   cfg_wr,
  input  wire logic      step,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic [7:0]  sync_first_r, sync_second_r;
  logic [8:0]  max_len_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [23:0] rcrc_r, rcrc_nxt;

  logic [31:0] crc_base, crc_upd;
  logic [15:0] full_len;
  logic [31:0] full_rcrc;
  logic        clear;

  // The command byte starts a fresh CRC.
  assign crc_base = (phase_r == PH_CMD) ? CRC_INIT : crc_r;

  cfp_crc u_crc (
    .crc_in  (crc_base),
    .data_in (item.rx_byte),
    .crc_out (crc_upd)
  );

  assign full_len  = {item.rx_byte, len_lo_r};
  assign full_rcrc = {item.rx_byte, rcrc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RESET;
      sync_second_r <= SYNC_SECOND_RESET;
      max_len_r     <= MAX_LEN_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wr.data[7:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_wr.data[7:0];
        CFG_MAX_LEN:     max_len_r     <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    seq_nxt    = seq_r;
    len_lo_nxt = len_lo_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    clear      = 1'b0;
    result     = '0;

    if (item.operation == OP_TIMEOUT) begin
      clear = 1'b1;
    end else begin
      case (phase_r)
        PH_SYNC0: begin
          if (item.rx_byte == sync_first_r) phase_nxt = PH_SYNC1;
        end
        PH_SYNC1: begin
          // A repeated first sync byte keeps the hunt armed.
          if (item.rx_byte == sync_second_r) phase_nxt = PH_CMD;
          else if (item.rx_byte != sync_first_r) clear = 1'b1;
        end
        PH_CMD: begin
          cmd_nxt   = item.rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = item.rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_lo_nxt = item.rx_byte;
          crc_nxt    = crc_upd;
          phase_nxt  = PH_LENHI;
        end
        PH_LENHI: begin
          if (full_len > {7'd0, max_len_r}) begin
            clear         = 1'b1;
            result.status = ST_PARSE_ERROR;
          end else begin
            len_nxt   = full_len[8:0];
            crc_nxt   = crc_upd;
            cnt_nxt   = '0;
            phase_nxt = (full_len == 16'd0) ? PH_CRC0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          result.payload_valid    = 1'b1;
          result.payload_byte     = item.rx_byte;
          result.payload_position = cnt_r;
          cnt_nxt = cnt_r + 9'd1;
          crc_nxt = crc_upd;
          if (cnt_nxt == len_r) phase_nxt = PH_CRC0;
        end
        PH_CRC0: begin
          rcrc_nxt[7:0] = item.rx_byte;
          phase_nxt     = PH_CRC1;
        end
        PH_CRC1: begin
          rcrc_nxt[15:8] = item.rx_byte;
          phase_nxt      = PH_CRC2;
        end
        PH_CRC2: begin
          rcrc_nxt[23:16] = item.rx_byte;
          phase_nxt       = PH_CRC3;
        end
        PH_CRC3: begin
          result.status         = ((crc_r ^ CRC_INIT) == full_rcrc) ? ST_FRAME_READY
                                                                    : ST_CRC_ERROR;
          result.frame_command  = cmd_r;
          result.frame_sequence = seq_r;
          result.frame_length   = len_r;
          result.frame_crc      = full_rcrc;
          clear = 1'b1;
        end
        default: begin
          clear         = 1'b1;
          result.status = ST_PARSE_ERROR;
        end
      endcase
    end

    if (clear) begin
      phase_nxt  = PH_SYNC0;
      cmd_nxt    = '0;
      seq_nxt    = '0;
      len_lo_nxt = '0;
      len_nxt    = '0;
      cnt_nxt    = '0;
      crc_nxt    = CRC_INIT;
      rcrc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC0;
      cmd_r    <= '0;
      seq_r    <= '0;
      len_lo_r <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= CRC_INIT;
      rcrc_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      seq_r    <= seq_nxt;
      len_lo_r <= len_lo_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/crc_framed_packet_parser.sv -----
// Top level of the framed packet parser: input word register, parser core, result register.
// Depends on cfp_pkg and cfp_parser.
//
// Usage: each input word is either a received byte or a receive timeout. Every accepted
// word gives exactly one result word: payload bytes are forwarded with their position,
// the last CRC byte reports frame ready or CRC error with the header fields, and an
// oversize length reports a parse error. A timeout returns the parser to the sync hunt.
// Channels: in_valid/in_ready/in_data, out_valid/out_ready/out_data, and a configuration
// write channel cfg_valid/cfg_ready/cfg_index/cfg_data that is always ready.
// Path: a word accepted from in_data is registered in the input register, processed by the
// parser logic, and its result is registered in the result register and shown on out_data.
// Throughput: one word per cycle while out_ready is high; the byte-wide CRC update and the
// phase machine between the input and result registers are both combinational.
// Reset: synchronous, active low; the registers return to sync bytes 0xA5 and 0x5A and
// a length limit of 260, the parser to the sync hunt, and both stages empty.
// Stall: while out_ready is low the result holds, the input register still takes one
// more word, and in_ready falls once both are full.
`default_nettype none

module crc_framed_packet_parser
  import cfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance, step, in_take;
  cfg_wr_t   cfg_wr;

  assign advance = !out_valid_r || out_ready;
  assign step    = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;
  assign in_take = in_valid && in_ready;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  cfp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .step   (step),
    .item   (in_item_r),
    .result (result)
  );

  always_comb begin
    in_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_item_r <= in_data;
    if (step) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

`default_nettype wire

// ----- src/cfp_checker.sv -----
// Port-level checker for the framed packet parser, bound to the top level.
// Depends on cfp_pkg.
`default_nettype none

module cfp_checker
  import cfp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Nothing comes out in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // A forwarded payload byte never ends a frame.
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.payload_valid |-> out_data.status == ST_IN_PROGRESS)
    else $error("payload word carries a final status");

  a_header_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FRAME_READY && out_data.status != ST_CRC_ERROR
    |-> out_data.frame_crc == 32'd0 && out_data.frame_length == 9'd0)
    else $error("header fields set without a finished frame");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.payload_valid
    |-> out_data.payload_byte == 8'd0 && out_data.payload_position == 9'd0)
    else $error("payload fields set on a non-payload word");

endmodule

bind crc_framed_packet_parser cfp_checker u_cfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
